FILE: sv/srfp_pkg.sv
package srfp_pkg;

   // Configuration port geometry.
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes, taken from paddr[4:2].
   typedef enum logic [2:0] {
      REG_START_CODE      = 3'd0,
      REG_END_CODE        = 3'd1,
      REG_ERROR_CODE      = 3'd2,
      REG_REPLY_CODE      = 3'd3,
      REG_EXPECTED_PARAMS = 3'd4,
      REG_COUNT_MODE      = 3'd5,
      REG_WIDE_LENGTH     = 3'd6,
      REG_WAIT_LIMIT      = 3'd7
   } reg_index_type;

   // Reset values of the registers.
   localparam logic [7:0]  START_CODE_RST      = 8'd224;
   localparam logic [7:0]  END_CODE_RST        = 8'd238;
   localparam logic [7:0]  ERROR_CODE_RST      = 8'd239;
   localparam logic [7:0]  REPLY_CODE_RST      = 8'd128;
   localparam logic [7:0]  EXPECTED_PARAMS_RST = 8'd1;
   localparam logic [14:0] WAIT_LIMIT_RST      = 15'd1000;

   typedef enum logic [1:0] {
      MODE_EXACT_SINGLE = 2'd0,
      MODE_ANY_SINGLE   = 2'd1,
      MODE_EXACT_MULTI  = 2'd2,
      MODE_CAPPED_MULTI = 2'd3
   } count_mode_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_FAIL = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_TIMEOUT    = 3'd1,
      STAT_ERROR_BYTE = 3'd2,
      STAT_REPLY      = 3'd3,
      STAT_COUNT      = 3'd4,
      STAT_ZERO_COUNT = 3'd5
   } status_type;

   // Parser phases, one-hot.
   typedef enum logic [7:0] {
      PH_WAIT     = 8'b0000_0001,
      PH_REPLY    = 8'b0000_0010,
      PH_COUNT    = 8'b0000_0100,
      PH_LEN_HI   = 8'b0000_1000,
      PH_LEN_LO   = 8'b0001_0000,
      PH_DATA     = 8'b0010_0000,
      PH_END      = 8'b0100_0000,
      PH_END_ZERO = 8'b1000_0000
   } phase_type;

   // Register contents handed from the register block to the parser.
   typedef struct packed {
      logic [7:0]     start_code;
      logic [7:0]     end_code;
      logic [7:0]     error_code;
      logic [7:0]     reply_code;
      logic [7:0]     expected_params;
      count_mode_type count_mode;
      logic           wide_length;
      logic [14:0]    wait_limit;
   } cfg_type;

endpackage

FILE: sv/srfp_if.sv
// Received byte channel.
interface srfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// Parse result channel.
interface srfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [7:0]  param_index;
   logic [15:0] byte_index;
   logic [15:0] param_length;
   logic        last_of_param;
   logic [2:0]  status;
   logic        end_ok;
   logic [7:0]  param_count;

   modport source (
      output valid, output kind, output data_byte, output param_index,
      output byte_index, output param_length, output last_of_param,
      output status, output end_ok, output param_count, input ready
   );
   modport sink (
      input valid, input kind, input data_byte, input param_index,
      input byte_index, input param_length, input last_of_param,
      input status, input end_ok, input param_count, output ready
   );
endinterface

FILE: sv/srfp_csr.sv
module srfp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [srfp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [srfp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [srfp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output srfp_pkg::cfg_type                 cfg
);
   import srfp_pkg::*;

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type sel;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign sel    = reg_index_type'(paddr[4:2]);
   assign cfg    = cfg_ff;

   // Register writes at the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code      <= START_CODE_RST;
         cfg_ff.end_code        <= END_CODE_RST;
         cfg_ff.error_code      <= ERROR_CODE_RST;
         cfg_ff.reply_code      <= REPLY_CODE_RST;
         cfg_ff.expected_params <= EXPECTED_PARAMS_RST;
         cfg_ff.count_mode      <= MODE_EXACT_SINGLE;
         cfg_ff.wide_length     <= 1'b0;
         cfg_ff.wait_limit      <= WAIT_LIMIT_RST;
      end else if (wr_en) begin
         case (sel)
            REG_START_CODE:      cfg_ff.start_code      <= pwdata[7:0];
            REG_END_CODE:        cfg_ff.end_code        <= pwdata[7:0];
            REG_ERROR_CODE:      cfg_ff.error_code      <= pwdata[7:0];
            REG_REPLY_CODE:      cfg_ff.reply_code      <= pwdata[7:0];
            REG_EXPECTED_PARAMS: cfg_ff.expected_params <= pwdata[7:0];
            REG_COUNT_MODE:      cfg_ff.count_mode      <= count_mode_type'(pwdata[1:0]);
            REG_WIDE_LENGTH:     cfg_ff.wide_length     <= pwdata[0];
            REG_WAIT_LIMIT:      cfg_ff.wait_limit      <= pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // Read back, zero extended.
   always_comb begin
      prdata = '0;
      case (sel)
         REG_START_CODE:      prdata[7:0]  = cfg_ff.start_code;
         REG_END_CODE:        prdata[7:0]  = cfg_ff.end_code;
         REG_ERROR_CODE:      prdata[7:0]  = cfg_ff.error_code;
         REG_REPLY_CODE:      prdata[7:0]  = cfg_ff.reply_code;
         REG_EXPECTED_PARAMS: prdata[7:0]  = cfg_ff.expected_params;
         REG_COUNT_MODE:      prdata[1:0]  = cfg_ff.count_mode;
         REG_WIDE_LENGTH:     prdata[0]    = cfg_ff.wide_length;
         REG_WAIT_LIMIT:      prdata[14:0] = cfg_ff.wait_limit;
         default:             prdata       = '0;
      endcase
   end

endmodule

FILE: sv/srfp_core.sv
module srfp_core (
   input  logic              clock,
   input  logic              reset,
   input  srfp_pkg::cfg_type cfg,
   srfp_req_if.sink          req,
   srfp_rsp_if.source        rsp
);
   import srfp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [14:0] wait_count_ff, wait_count_in;
   logic [7:0]  count_taken_ff, count_taken_in;
   logic [7:0]  current_param_ff, current_param_in;
   logic [15:0] current_length_ff, current_length_in;
   logic [15:0] bytes_seen_ff, bytes_seen_in;

   logic        rsp_valid_ff;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  data_byte_ff, data_byte_in;
   logic [7:0]  param_index_ff, param_index_in;
   logic [15:0] byte_index_ff, byte_index_in;
   logic [15:0] param_length_ff, param_length_in;
   logic        last_ff, last_in;
   logic [2:0]  status_ff, status_in;
   logic        end_ok_ff, end_ok_in;
   logic [7:0]  param_count_ff;

   logic        accept;
   logic        emit;
   logic [7:0]  b;
   logic        single;
   logic        wide;
   phase_type   len_phase;
   logic [7:0]  param_next;
   logic [7:0]  param_target;
   logic        more_params;
   logic [15:0] seen_next;
   logic        data_last;
   logic [15:0] length_lo;

   // The result register frees itself in the cycle it is taken.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign b         = req.rx_byte;

   // Shared decodes for starting a parameter and stepping to the next one.
   assign single       = (cfg.count_mode == MODE_EXACT_SINGLE) ||
                         (cfg.count_mode == MODE_ANY_SINGLE);
   assign wide         = single && cfg.wide_length;
   assign len_phase    = wide ? PH_LEN_HI : PH_LEN_LO;
   assign param_next   = current_param_ff + 8'd1;
   assign param_target = single ? 8'd1 : count_taken_ff;
   assign more_params  = param_next < param_target;
   assign seen_next    = bytes_seen_ff + 16'd1;
   assign data_last    = seen_next >= current_length_ff;
   assign length_lo    = {current_length_ff[15:8], b};

   // Next state and result for one received byte.
   always_comb begin
      phase_in          = phase_ff;
      wait_count_in     = wait_count_ff;
      count_taken_in    = count_taken_ff;
      current_param_in  = current_param_ff;
      current_length_in = current_length_ff;
      bytes_seen_in     = bytes_seen_ff;
      emit              = 1'b0;
      kind_in           = KIND_FAIL;
      data_byte_in      = '0;
      param_index_in    = '0;
      byte_index_in     = '0;
      param_length_in   = '0;
      last_in           = 1'b0;
      status_in         = STAT_OK;
      end_ok_in         = 1'b0;
      case (phase_ff)
         PH_WAIT: begin
            if (b == cfg.error_code) begin
               wait_count_in = '0;
               emit          = 1'b1;
               status_in     = STAT_ERROR_BYTE;
            end else if (b == cfg.start_code) begin
               wait_count_in     = '0;
               count_taken_in    = '0;
               current_param_in  = '0;
               current_length_in = '0;
               bytes_seen_in     = '0;
               phase_in          = PH_REPLY;
            end else if (wait_count_ff >= cfg.wait_limit) begin
               wait_count_in = '0;
               emit          = 1'b1;
               status_in     = STAT_TIMEOUT;
            end else begin
               wait_count_in = wait_count_ff + 15'd1;
            end
         end
         PH_REPLY: begin
            if (b != cfg.reply_code) begin
               phase_in  = PH_WAIT;
               emit      = 1'b1;
               status_in = STAT_REPLY;
            end else begin
               phase_in = PH_COUNT;
            end
         end
         PH_COUNT: begin
            current_param_in = '0;
            count_taken_in   = b;
            case (cfg.count_mode)
               MODE_EXACT_SINGLE: begin
                  if (b != cfg.expected_params) begin
                     phase_in  = PH_WAIT;
                     emit      = 1'b1;
                     status_in = STAT_COUNT;
                  end
               end
               MODE_ANY_SINGLE: begin
               end
               MODE_EXACT_MULTI: begin
                  if (b == 8'd0) begin
                     phase_in  = PH_WAIT;
                     emit      = 1'b1;
                     status_in = STAT_ZERO_COUNT;
                  end else if (b != cfg.expected_params) begin
                     phase_in  = PH_WAIT;
                     emit      = 1'b1;
                     status_in = STAT_COUNT;
                  end
               end
               default: begin
                  count_taken_in = (b > cfg.expected_params) ? cfg.expected_params : b;
               end
            endcase
            // Without a failure the frame goes on to a length or to its end.
            if (!emit) begin
               if (cfg.count_mode == MODE_ANY_SINGLE && b == 8'd0) begin
                  phase_in = PH_END;
               end else if (cfg.count_mode == MODE_CAPPED_MULTI &&
                            count_taken_in == 8'd0) begin
                  phase_in = PH_END_ZERO;
               end else begin
                  current_length_in = '0;
                  bytes_seen_in     = '0;
                  phase_in          = len_phase;
               end
            end
         end
         PH_LEN_HI: begin
            current_length_in = {b, 8'd0};
            phase_in          = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            current_length_in = length_lo;
            bytes_seen_in     = '0;
            if (length_lo == 16'd0) begin
               current_param_in = param_next;
               if (more_params) begin
                  current_length_in = '0;
                  phase_in          = len_phase;
               end else begin
                  phase_in = PH_END;
               end
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            emit            = 1'b1;
            kind_in         = KIND_DATA;
            data_byte_in    = b;
            param_index_in  = current_param_ff;
            byte_index_in   = bytes_seen_ff;
            param_length_in = current_length_ff;
            last_in         = data_last;
            bytes_seen_in   = seen_next;
            if (data_last) begin
               current_param_in = param_next;
               if (more_params) begin
                  current_length_in = '0;
                  bytes_seen_in     = '0;
                  phase_in          = len_phase;
               end else begin
                  phase_in = PH_END;
               end
            end
         end
         PH_END: begin
            emit      = 1'b1;
            kind_in   = KIND_DONE;
            end_ok_in = (b == cfg.end_code);
            phase_in  = PH_WAIT;
         end
         PH_END_ZERO: begin
            emit      = 1'b1;
            status_in = STAT_ZERO_COUNT;
            end_ok_in = (b == cfg.end_code);
            phase_in  = PH_WAIT;
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_WAIT;
         wait_count_ff     <= '0;
         count_taken_ff    <= '0;
         current_param_ff  <= '0;
         current_length_ff <= '0;
         bytes_seen_ff     <= '0;
      end else if (accept) begin
         phase_ff          <= phase_in;
         wait_count_ff     <= wait_count_in;
         count_taken_ff    <= count_taken_in;
         current_param_ff  <= current_param_in;
         current_length_ff <= current_length_in;
         bytes_seen_ff     <= bytes_seen_in;
      end
   end

   // Result word valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result word payload.
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff         <= kind_in;
         data_byte_ff    <= data_byte_in;
         param_index_ff  <= param_index_in;
         byte_index_ff   <= byte_index_in;
         param_length_ff <= param_length_in;
         last_ff         <= last_in;
         status_ff       <= status_in;
         end_ok_ff       <= end_ok_in;
         param_count_ff  <= count_taken_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kind          = kind_ff;
   assign rsp.data_byte     = data_byte_ff;
   assign rsp.param_index   = param_index_ff;
   assign rsp.byte_index    = byte_index_ff;
   assign rsp.param_length  = param_length_ff;
   assign rsp.last_of_param = last_ff;
   assign rsp.status        = status_ff;
   assign rsp.end_ok        = end_ok_ff;
   assign rsp.param_count   = param_count_ff;

endmodule

FILE: sv/spi_response_frame_parser.sv
// Reply frame parser, one received byte per word.
// A result is registered onto rsp in the cycle after its byte is taken.
// Throughput: one byte per cycle while rsp is ready; the single result
// register refills in the cycle it is taken; a held result stalls bytes.
// Reset (synchronous, active high) returns the parser to waiting for the start
// byte, empties the result register and loads the register defaults.
module spi_response_frame_parser (
   input  logic                              clock,
   input  logic                              reset,
   srfp_req_if.sink                          req,
   srfp_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [srfp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [srfp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [srfp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import srfp_pkg::*;

   cfg_type cfg;

   // Register block.
   srfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Frame parser with its result register.
   srfp_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

FILE: sv/srfp_checker.sv
module srfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [2:0]  rsp_status,
   input logic        rsp_end_ok,
   input logic [7:0]  rsp_data_byte
);
   import srfp_pkg::*;

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_status) && $stable(rsp_data_byte))
      else $error("stalled result word changed");

   // Data words carry no status and no end flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DATA |-> rsp_status == STAT_OK && !rsp_end_ok)
      else $error("data word with status or end flag");

   // A finished frame always reports ok.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DONE |-> rsp_status == STAT_OK)
      else $error("done word with failure status");

   // A failure always names a cause.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FAIL |-> rsp_status != STAT_OK &&
         rsp_data_byte == 8'd0)
      else $error("failed word without cause");

   // The result register is empty in the first cycle after reset is released.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind spi_response_frame_parser srfp_checker u_srfp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_kind      (rsp.kind),
   .rsp_status    (rsp.status),
   .rsp_end_ok    (rsp.end_ok),
   .rsp_data_byte (rsp.data_byte)
);
